// ===== rtl/core/srrv_pkg.sv =====
// Shared types and constants for the sector request retry validator.
// No dependencies; compile first.
package srrv_pkg;

    localparam int HDR_KEPT = 14;

    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h04;

    localparam logic [1:0] ATTEMPTS_RETRY  = 2'd3;
    localparam logic [1:0] ATTEMPTS_SINGLE = 2'd1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SIZE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ID        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VERSION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SLOT       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_COUNT       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE       = 3'd5;

    localparam logic [6:0]  RST_HEADER_SIZE      = 7'd8;
    localparam logic [7:0]  RST_DEVICE_ID        = 8'd0;
    localparam logic [7:0]  RST_PROTOCOL_VERSION = 8'd1;
    localparam logic [7:0]  RST_FIRST_SLOT       = 8'd1;
    localparam logic [7:0]  RST_UNIT_COUNT       = 8'd8;
    localparam logic [15:0] RST_BLOCK_SIZE       = 16'd512;

    typedef struct packed {
        logic [6:0]  header_size;
        logic [7:0]  device_id;
        logic [7:0]  protocol_version;
        logic [7:0]  first_slot;
        logic [7:0]  unit_count;
        logic [15:0] block_size;
    } cfg_t;

    typedef logic [HDR_KEPT-1:0][7:0] hdr_t;

    // Packet state after the current word has been folded in.
    typedef struct packed {
        hdr_t        hdr;
        logic [15:0] len;
        logic        too_long;
        logic [7:0]  sum;
    } pkt_t;

endpackage

// ===== rtl/core/srrv_ifs.sv =====
// Valid/ready channel interfaces for the request byte stream and the result.
// Depends on nothing; compile after srrv_pkg.
interface srrv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srrv_out_if;
    logic       valid;
    logic       ready;
    logic       retryable;
    logic [1:0] attempt_limit;
    logic [7:0] computed_sum;

    modport source (output valid, output retryable, output attempt_limit,
                    output computed_sum, input ready);
    modport sink   (input valid, input retryable, input attempt_limit,
                    input computed_sum, output ready);
endinterface

// ===== rtl/core/srrv_check.sv =====
// Header checks of a finished request packet against the configuration.
// Depends on srrv_pkg.
module srrv_check
(
    input  srrv_pkg::cfg_t cfg,
    input  srrv_pkg::pkt_t pkt,
    output logic           ok
);

    logic [15:0] enc_len;
    logic [15:0] sec_len;
    logic [17:0] len_x;
    logic [17:0] read_len;
    logic [17:0] write_len;
    logic [8:0]  slot_x;
    logic [8:0]  slot_end;
    logic        len_ok;
    logic        cmd_ok;
    logic        slot_ok;

    always_comb
    begin
        enc_len   = {pkt.hdr[3], pkt.hdr[2]};
        sec_len   = {pkt.hdr[13], pkt.hdr[12]};
        len_x     = {2'b00, pkt.len};
        read_len  = {11'd0, cfg.header_size} + 18'd8;
        write_len = read_len + {2'b00, cfg.block_size};
        slot_x    = {1'b0, pkt.hdr[7]};
        slot_end  = {1'b0, cfg.first_slot} + {1'b0, cfg.unit_count};

        len_ok  = !pkt.too_long && (pkt.len >= {9'd0, cfg.header_size});
        cmd_ok  = ((pkt.hdr[1] == srrv_pkg::CMD_READ)  && (len_x == read_len)) ||
                  ((pkt.hdr[1] == srrv_pkg::CMD_WRITE) && (len_x == write_len));
        slot_ok = (slot_x >= {1'b0, cfg.first_slot}) && (slot_x < slot_end);

        ok = len_ok && cmd_ok && slot_ok &&
             (pkt.hdr[0] == cfg.device_id) &&
             (enc_len == pkt.len) &&
             (pkt.hdr[4] == pkt.sum) &&
             (pkt.hdr[5] == 8'd0) &&
             (pkt.hdr[6] == cfg.protocol_version) &&
             (sec_len == cfg.block_size);
    end

endmodule

// ===== rtl/core/sector_request_retry_validator_top.sv =====
// Top level of the sector request retry validator.
// Depends on srrv_pkg, srrv_ifs (srrv_in_if, srrv_out_if) and srrv_check.
//
// The block takes a request packet one word (byte) per cycle on in_ch, the
// final word marked by last_byte, and answers each packet with one result word
// on out_ch: retryable is set when the packet is a well-formed sector read
// (command 3) or sector write (command 4) addressed to this device, with the
// configured protocol version, a slot inside the window first_slot ..
// first_slot+unit_count-1, the right encoded length, sector length and
// checksum; attempt_limit is then 3, otherwise 1; computed_sum is the
// end-around-carry sum of every byte except byte four. Non-final words make no
// result. Throughput is one word per cycle while in_ch.ready is high: a word
// is registered on acceptance, folded into the packet state when it leaves the
// input stage, and on the final word the result register loads in that same
// cycle, once out_ch has taken any earlier result. in_ch.ready drops only
// while a final word waits behind a result that out_ch has not taken. Write the
// configuration port only while no packet is in flight.

module sector_request_retry_validator_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    srrv_in_if.sink                               in_ch,
    srrv_out_if.source                            out_ch,
    input  logic                                  cfg_we,
    input  logic [srrv_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [srrv_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers.
    srrv_pkg::cfg_t cfg_reg;

    // Input stage: the accepted word waits here until it is folded in.
    logic        s1_valid_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_last_reg;

    // Packet state carried across words.
    logic [15:0]     pos_reg;
    logic            too_long_reg;
    logic [7:0]      sum_reg;
    srrv_pkg::hdr_t  hdr_reg;

    // Result register.
    logic        out_valid_reg;
    logic        retryable_reg;
    logic [1:0]  attempt_limit_reg;
    logic [7:0]  computed_sum_reg;

    logic            in_accept;
    logic            out_free;
    logic            advance;
    logic            load_result;
    logic            saturated;
    logic [8:0]      sum_wide;
    srrv_pkg::pkt_t  pkt_next;
    logic            pkt_ok;

    assign out_free    = !out_valid_reg || out_ch.ready;
    // A non-final word always moves on; a final word needs the result register.
    assign advance     = s1_valid_reg && (!s1_last_reg || out_free);
    assign load_result = advance && s1_last_reg;
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_accept   = in_ch.valid && in_ch.ready;

    // Fold the staged word into the packet state.
    always_comb
    begin
        saturated         = too_long_reg || (pos_reg == 16'hFFFF);
        sum_wide          = {1'b0, sum_reg} + {1'b0, s1_data_reg};
        pkt_next.hdr      = hdr_reg;
        pkt_next.sum      = sum_reg;
        pkt_next.too_long = saturated;
        pkt_next.len      = saturated ? 16'hFFFF : pos_reg + 16'd1;

        // Byte four carries the checksum itself; leave it out of the sum,
        // except once the packet has run past the position counter.
        if (saturated || (pos_reg != 16'd4))
        begin
            pkt_next.sum = sum_wide[7:0] + {7'd0, sum_wide[8]};
        end

        if (!saturated && (pos_reg < 16'(srrv_pkg::HDR_KEPT)))
        begin
            pkt_next.hdr[pos_reg[3:0]] = s1_data_reg;
        end
    end

    srrv_check u_check
    (
        .cfg (cfg_reg),
        .pkt (pkt_next),
        .ok  (pkt_ok)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_size      <= srrv_pkg::RST_HEADER_SIZE;
            cfg_reg.device_id        <= srrv_pkg::RST_DEVICE_ID;
            cfg_reg.protocol_version <= srrv_pkg::RST_PROTOCOL_VERSION;
            cfg_reg.first_slot       <= srrv_pkg::RST_FIRST_SLOT;
            cfg_reg.unit_count       <= srrv_pkg::RST_UNIT_COUNT;
            cfg_reg.block_size       <= srrv_pkg::RST_BLOCK_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srrv_pkg::REG_HEADER_SIZE:      cfg_reg.header_size      <= cfg_data[6:0];
                srrv_pkg::REG_DEVICE_ID:        cfg_reg.device_id        <= cfg_data[7:0];
                srrv_pkg::REG_PROTOCOL_VERSION: cfg_reg.protocol_version <= cfg_data[7:0];
                srrv_pkg::REG_FIRST_SLOT:       cfg_reg.first_slot       <= cfg_data[7:0];
                srrv_pkg::REG_UNIT_COUNT:       cfg_reg.unit_count       <= cfg_data[7:0];
                srrv_pkg::REG_BLOCK_SIZE:       cfg_reg.block_size       <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= in_ch.data_byte;
            s1_last_reg <= in_ch.last_byte;
        end
    end

    // Packet state: advance on every word, clear after the final one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 16'd0;
            too_long_reg <= 1'b0;
            sum_reg      <= 8'd0;
            hdr_reg      <= '0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                pos_reg      <= 16'd0;
                too_long_reg <= 1'b0;
                sum_reg      <= 8'd0;
                hdr_reg      <= '0;
            end
            else
            begin
                pos_reg      <= pkt_next.len;
                too_long_reg <= pkt_next.too_long;
                sum_reg      <= pkt_next.sum;
                hdr_reg      <= pkt_next.hdr;
            end
        end
    end

    // Result register control: hold until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            retryable_reg     <= pkt_ok;
            attempt_limit_reg <= pkt_ok ? srrv_pkg::ATTEMPTS_RETRY
                                        : srrv_pkg::ATTEMPTS_SINGLE;
            computed_sum_reg  <= pkt_next.sum;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.retryable     = retryable_reg;
    assign out_ch.attempt_limit = attempt_limit_reg;
    assign out_ch.computed_sum  = computed_sum_reg;

endmodule

// ===== rtl/core/srrv_checker.sv =====
// Port-level assertions for the sector request retry validator, bound to the top.
// Depends on sector_request_retry_validator_top.
module srrv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       retryable,
    input logic [1:0] attempt_limit,
    input logic [7:0] computed_sum
);

    // A stalled result holds its word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(retryable) &&
                                    $stable(attempt_limit) && $stable(computed_sum))
        else $error("result word changed while stalled");

    // Attempt limit follows the verdict.
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (retryable ? (attempt_limit == 2'd3) : (attempt_limit == 2'd1)))
        else $error("attempt limit does not match retryable");

    // Input backpressure only comes from a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

    // A quiet input with no result pending leaves the input stage empty, so no
    // result can follow from it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready)) ##1 !out_valid |=> !out_valid)
        else $error("result appeared without a final word");

endmodule

bind sector_request_retry_validator_top srrv_checker u_srrv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .retryable     (out_ch.retryable),
    .attempt_limit (out_ch.attempt_limit),
    .computed_sum  (out_ch.computed_sum)
);

// ===== verif/sector_request_retry_validator_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sector_request_retry_validator_top: streams request
// packets word by word, predicts each verdict and checks it on the result channel.
// Depends on srrv_pkg, srrv_ifs and the RTL of the block.
module sector_request_retry_validator_top_tb;

    import srrv_pkg::*;

    // Indexes past the last register: writes to them must leave everything alone.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT   = 5000; // cycles with no word moving on either channel
    localparam int SETTLE_CYCLES = 4;    // wait after the last verdict is taken
    localparam int TAIL_CYCLES   = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 500;
    localparam int RANDOM_PKTS   = 48;

    // Ways to spoil an otherwise well-formed request, one rule at a time.
    typedef enum int {
        F_NONE,
        F_DEVICE,
        F_COMMAND,
        F_LENGTH_SHORT,
        F_LENGTH_LONG,
        F_ENCODED,
        F_CHECKSUM,
        F_RESERVED,
        F_VERSION,
        F_SLOT,
        F_SECTOR
    } fault_e;

    // Receiver behavior, switched at random.
    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_RUNS
    } rx_mode_e;

    typedef struct packed {
        logic       retryable;
        logic [1:0] attempt_limit;
        logic [7:0] computed_sum;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    srrv_in_if  in_ch ();
    srrv_out_if out_ch ();

    sector_request_retry_validator_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register values as the block should hold them.
    cfg_t        rc;

    // Packet state of the predictor.
    int unsigned pk_pos;
    logic        pk_too_long;
    logic [7:0]  pk_sum;
    logic [7:0]  pk_hdr [HDR_KEPT];

    // Verdicts still owed by the block, oldest first.
    verdict_t    verdict_q [$];

    int          mismatches;
    int          words_sent;
    int          stall_cycles;

    // Sender burst state.
    int          burst_left;
    bit          sender_calm;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Add one byte into an 8-bit sum with end-around carry.
    function automatic logic [7:0] fold_sum(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

    function automatic void clear_packet();
        pk_pos      = 0;
        pk_too_long = 1'b0;
        pk_sum      = 8'h00;
        foreach (pk_hdr[i])
            pk_hdr[i] = 8'h00;
    endfunction

    // Decide whether the packet just closed is a sector request worth retrying.
    // All sums are done at 32 bits so nothing wraps.
    function automatic bit request_ok(input int unsigned len);
        int unsigned enc;
        int unsigned sec;
        int unsigned need;
        int unsigned slot;
        enc  = 32'({pk_hdr[3], pk_hdr[2]});
        sec  = 32'({pk_hdr[13], pk_hdr[12]});
        slot = 32'(pk_hdr[7]);
        if (pk_too_long || len < rc.header_size)
            return 1'b0;
        if (pk_hdr[1] == CMD_READ)
            need = rc.header_size + 8;
        else if (pk_hdr[1] == CMD_WRITE)
            need = rc.header_size + 8 + rc.block_size;
        else
            return 1'b0;
        if (len != need)
            return 1'b0;
        return pk_hdr[0] == rc.device_id &&
               enc == len &&
               pk_hdr[4] == pk_sum &&
               pk_hdr[5] == 8'h00 &&
               pk_hdr[6] == rc.protocol_version &&
               slot >= rc.first_slot &&
               slot < int'(rc.first_slot) + int'(rc.unit_count) &&
               sec == rc.block_size;
    endfunction

    // Fold one accepted word into the packet state; queue a verdict on the last word.
    function automatic void fold_word(input logic [7:0] b, input logic last);
        verdict_t v;
        bit       ok;
        if (pk_too_long || pk_pos >= 32'hFFFF)
        begin
            // Saturate the position and keep summing.
            pk_too_long = 1'b1;
            pk_pos      = 32'hFFFF;
            pk_sum      = fold_sum(pk_sum, b);
        end
        else
        begin
            // Byte four carries the checksum itself, so skip it.
            if (pk_pos != 4)
                pk_sum = fold_sum(pk_sum, b);
            if (pk_pos < HDR_KEPT)
                pk_hdr[pk_pos] = b;
            pk_pos++;
        end
        if (last)
        begin
            ok              = request_ok(pk_pos);
            v.retryable     = ok;
            v.attempt_limit = ok ? ATTEMPTS_RETRY : ATTEMPTS_SINGLE;
            v.computed_sum  = pk_sum;
            verdict_q.push_back(v);
            clear_packet();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Checker and watchdog: sample on the rising edge only
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with nothing expected: retry=%0b limit=%0d sum=%02h",
                             $realtime, out_ch.retryable, out_ch.attempt_limit,
                             out_ch.computed_sum);
            end
            else
            begin
                want = verdict_q.pop_front();
                if (out_ch.retryable !== want.retryable ||
                    out_ch.attempt_limit !== want.attempt_limit ||
                    out_ch.computed_sum !== want.computed_sum)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] verdict mismatch: exp retry=%0b limit=%0d sum=%02h, %s%0b %s%0d %s%02h",
                                 $realtime, want.retryable, want.attempt_limit,
                                 want.computed_sum,
                                 "got retry=", out_ch.retryable,
                                 "limit=", out_ch.attempt_limit,
                                 "sum=", out_ch.computed_sum);
                end
            end
        end

        // Count cycles in which nothing moves; a hung block ends the run here.
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sector_request_retry_validator_top_tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode every so often
    // ---------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_e mode;
        int       mode_left;
        int       run_left;
        bit       stalled;
        mode      = RX_OPEN;
        mode_left = 0;
        run_left  = 0;
        stalled   = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_e'($urandom_range(RX_OPEN, RX_RUNS));
                mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            case (mode)
                RX_OPEN:   out_ch.ready = 1'b1;
                RX_MOSTLY: out_ch.ready = ($urandom_range(0, 3) != 0);
                RX_SPARSE: out_ch.ready = ($urandom_range(0, 3) == 0);
                default:
                begin
                    // Alternate runs of stall and take.
                    if (run_left == 0)
                    begin
                        stalled  = !stalled;
                        run_left = stalled ? $urandom_range(1, 12) : $urandom_range(1, 6);
                    end
                    run_left--;
                    out_ch.ready = !stalled;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sender side: every task is entered and left at a falling edge
    // ---------------------------------------------------------------------

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        if (!sender_calm)
        begin
            if (burst_left == 0)
            begin
                // Drop valid for a gap, then start a fresh burst.
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 30);
            end
            burst_left--;
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        in_ch.last_byte = last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        fold_word(b, last);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet(input logic [7:0] pkt [$]);
        foreach (pkt[i])
            send_word(pkt[i], i == pkt.size() - 1);
    endtask

    // Hold off the sender until every verdict is in and the block has gone quiet.
    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; only call with the block idle.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_HEADER_SIZE:      rc.header_size      = value[6:0];
            REG_DEVICE_ID:        rc.device_id        = value[7:0];
            REG_PROTOCOL_VERSION: rc.protocol_version = value[7:0];
            REG_FIRST_SLOT:       rc.first_slot       = value[7:0];
            REG_UNIT_COUNT:       rc.unit_count       = value[7:0];
            REG_BLOCK_SIZE:       rc.block_size       = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input int hs, input int dev, input int ver,
                              input int first, input int units, input int bsz);
        drain_results();
        cfg_write(REG_HEADER_SIZE, 16'(hs));
        cfg_write(REG_DEVICE_ID, 16'(dev));
        cfg_write(REG_PROTOCOL_VERSION, 16'(ver));
        cfg_write(REG_FIRST_SLOT, 16'(first));
        cfg_write(REG_UNIT_COUNT, 16'(units));
        cfg_write(REG_BLOCK_SIZE, 16'(bsz));
    endtask

    // Build a request that matches the current registers, then spoil at most one rule.
    // slot_pick < 0 picks a slot inside the window, or first_slot when the window is empty.
    task automatic build_request(input logic [7:0] cmd, input fault_e fault, input int slot_pick,
                                 output logic [7:0] pkt [$]);
        logic [7:0]  img [HDR_KEPT];
        int unsigned len;
        int unsigned top;
        logic [15:0] enc;
        logic [7:0]  sum;
        pkt = {};
        len = rc.header_size + 8;
        if (cmd == CMD_WRITE)
            len += rc.block_size;
        if (fault == F_LENGTH_SHORT)
            len = (len > 1) ? len - 1 : len + 2;
        if (fault == F_LENGTH_LONG)
            len += $urandom_range(1, 3);
        foreach (img[i])
            img[i] = 8'($urandom_range(0, 255));
        enc    = len[15:0];
        img[0] = rc.device_id;
        img[1] = cmd;
        img[5] = 8'h00;
        img[6] = rc.protocol_version;
        if (slot_pick >= 0)
            img[7] = slot_pick[7:0];
        else if (rc.unit_count == 0)
            img[7] = rc.first_slot;
        else
        begin
            top = rc.first_slot + rc.unit_count - 1;
            if (top > 255)
                top = 255;
            img[7] = 8'($urandom_range(rc.first_slot, top));
        end
        {img[13], img[12]} = rc.block_size;
        case (fault)
            F_DEVICE:   img[0] ^= 8'($urandom_range(1, 255));
            F_COMMAND:
            begin
                do
                    img[1] = 8'($urandom_range(0, 255));
                while (img[1] == CMD_READ || img[1] == CMD_WRITE);
            end
            F_ENCODED:  enc ^= 16'($urandom_range(1, 65535));
            F_RESERVED: img[5] = 8'($urandom_range(1, 255));
            F_VERSION:  img[6] ^= 8'($urandom_range(1, 255));
            F_SLOT:
            begin
                // Step just outside the window on either side.
                if (rc.first_slot > 0 && $urandom_range(0, 1))
                    img[7] = rc.first_slot - 8'd1;
                else
                    img[7] = rc.first_slot + rc.unit_count;
            end
            F_SECTOR:   img[12] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        {img[3], img[2]} = enc;
        for (int unsigned i = 0; i < len; i++)
            pkt.push_back((i < HDR_KEPT) ? img[i] : 8'($urandom_range(0, 255)));
        sum = 8'h00;
        foreach (pkt[i])
            if (i != 4)
                sum = fold_sum(sum, pkt[i]);
        if (fault == F_CHECKSUM)
            sum ^= 8'($urandom_range(1, 255));
        if (len > 4)
            pkt[4] = sum;
    endtask

    task automatic send_request(input logic [7:0] cmd, input fault_e fault, input int slot_pick);
        logic [7:0] pkt [$];
        build_request(cmd, fault, slot_pick, pkt);
        send_packet(pkt);
    endtask

    // A packet of the given length, of random bytes or, with fill not negative, all fill.
    task automatic send_noise(input int n, input int fill);
        logic [7:0] pkt [$];
        pkt = {};
        repeat (n)
            pkt.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        send_packet(pkt);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset register values: good read and write, plus noise packets.
    task automatic test_reset_defaults();
        send_request(CMD_READ, F_NONE, -1);
        send_request(CMD_WRITE, F_NONE, -1);
        send_noise(1, 255);     // lone final word
        send_noise(4, 0);       // short, all zero, header offsets past the end read zero
        send_noise(16, 255);
        send_noise(3, -1);      // header copy must have been cleared by now
    endtask

    // Break each rule on its own; everything else stays well-formed.
    task automatic test_single_faults();
        for (int f = F_DEVICE; f <= F_SECTOR; f++)
            send_request(CMD_READ, fault_e'(f), -1);
        set_config(8, 0, 1, 1, 8, 6);
        send_request(CMD_WRITE, F_CHECKSUM, -1);
        send_request(CMD_WRITE, F_LENGTH_LONG, -1);
        send_request(CMD_WRITE, F_NONE, -1);
    endtask

    // Registers at their extremes, including the cases with no valid slot
    // and a header size below the usual minimum.
    task automatic test_config_extremes();
        set_config(6, 255, 0, 0, 255, 1);
        send_request(CMD_READ, F_NONE, 0);
        send_request(CMD_WRITE, F_NONE, 254);
        send_request(CMD_READ, F_NONE, 255);    // one past the window

        set_config(64, 8'h5A, 255, 255, 255, 2);
        send_request(CMD_READ, F_NONE, 255);    // window end beyond 8 bits
        send_request(CMD_WRITE, F_NONE, -1);

        set_config(6, 8'hA5, 8'h33, 17, 0, 3);
        send_request(CMD_READ, F_NONE, 17);     // zero unit count: never valid

        set_config(0, 1, 2, 3, 4, 0);           // packet shorter than the sector field
        send_request(CMD_READ, F_NONE, -1);
        send_request(CMD_WRITE, F_NONE, -1);

        set_config(127, 8'h80, 8'h7F, 8'h80, 1, 1);
        send_request(CMD_READ, F_NONE, -1);

        // Writes past the last register must change nothing.
        drain_results();
        cfg_write(REG_SPARE_LO, 16'($urandom_range(0, 65535)));
        cfg_write(REG_SPARE_HI, 16'($urandom_range(0, 65535)));
        send_request(CMD_READ, F_NONE, -1);
    endtask

    // Longest legal packet, and one that runs past the position counter.
    task automatic test_length_limits();
        sender_calm = 1'b1;
        set_config(8, 8'h42, 8'h01, 1, 8, 65535 - 8 - 8);
        send_request(CMD_WRITE, F_NONE, -1);    // exactly 65535 words
        set_config(8, 8'h42, 8'h01, 1, 8, 65535);
        send_request(CMD_READ, F_NONE, -1);
        send_request(CMD_WRITE, F_NONE, -1);    // write size beyond 16 bits: saturates
        send_request(CMD_READ, F_NONE, -1);     // state must be clean again
        sender_calm = 1'b0;
    endtask

    task automatic random_config();
        int hs;
        int bsz;
        int units;
        hs    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(6, 20);
        bsz   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 600) : $urandom_range(0, 24);
        units = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255);
        set_config(hs, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), units, bsz);
    endtask

    // Mostly well-formed requests with random content, some spoiled, some noise
    // and some cut short.
    task automatic test_random_traffic();
        int         start_words;
        int         pkts;
        int         pick;
        int         cut;
        logic [7:0] cmd;
        logic [7:0] pkt [$];
        start_words = words_sent;
        pkts        = 0;
        while (words_sent - start_words < RANDOM_WORDS || pkts < RANDOM_PKTS)
        begin
            if (pkts % 12 == 0)
                random_config();
            pick = $urandom_range(0, 99);
            cmd  = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
            if (pick < 45)
                send_request(cmd, F_NONE, -1);
            else if (pick < 70)
                send_request(cmd, fault_e'($urandom_range(F_DEVICE, F_SECTOR)), -1);
            else if (pick < 85)
                send_noise($urandom_range(1, 20), -1);
            else
            begin
                // Close a good request early, or at times at its full length.
                build_request(cmd, F_NONE, -1, pkt);
                cut = $urandom_range(1, pkt.size());
                while (pkt.size() > cut)
                    void'(pkt.pop_back());
                send_packet(pkt);
            end
            pkts++;
            // Now and then let every verdict come home before going on.
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_HEADER_SIZE;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        rc              = '{RST_HEADER_SIZE, RST_DEVICE_ID, RST_PROTOCOL_VERSION,
                            RST_FIRST_SLOT, RST_UNIT_COUNT, RST_BLOCK_SIZE};
        mismatches      = 0;
        words_sent      = 0;
        stall_cycles    = 0;
        burst_left      = 0;
        sender_calm     = 1'b0;
        clear_packet();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_single_faults();
        test_config_extremes();
        test_length_limits();
        test_random_traffic();

        // Wait out the last verdicts; the watchdog bounds this.
        in_ch.valid = 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("sector_request_retry_validator_top_tb: clean");
        else
            $display("sector_request_retry_validator_top_tb: errors");
        $finish;
    end

endmodule
